FILE: rtl/core/two_phase_task_dispatcher_assert.svh
// assertion macros used by the dispatcher checker
`ifndef TWO_PHASE_TASK_DISPATCHER_ASSERT_SVH
`define TWO_PHASE_TASK_DISPATCHER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define TDT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dispatcher check failed in the same cycle");

// consequent must hold in the cycle after the antecedent
`define TDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dispatcher check failed one cycle later");

`endif

FILE: rtl/core/tdt_pkg.sv
// shared types and constants of the two-phase task dispatcher
`default_nettype none
package tdt_pkg;

	localparam int TASKS_MAX  = 64;
	localparam int IDX_W      = 6;
	localparam int CNT_W      = 7;
	localparam int ADDR_W     = IDX_W + 1;
	localparam int DEPTH      = 2 * TASKS_MAX;
	localparam int WORKER_W   = 4;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int TDATA_W    = 16;

	// entry status codes
	localparam logic [STATUS_W-1:0] ST_UNASSIGNED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_PENDING    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_COMPLETED  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAP_COUNT    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REDUCE_COUNT = 1'd1;

	// message and reply codes
	localparam logic REQ_TASK       = 1'b0;
	localparam logic REQ_DONE       = 1'b1;
	localparam logic KIND_MAP       = 1'b0;
	localparam logic KIND_REDUCE    = 1'b1;
	localparam logic REPLY_ASSIGNED = 1'b0;
	localparam logic REPLY_NONE     = 1'b1;

	// one worker message
	typedef struct packed {
		logic                req_type;
		logic [WORKER_W-1:0] worker;
		logic                kind;
		logic [IDX_W-1:0]    idx;
	} item_t;

	// one reply
	typedef struct packed {
		logic                code;
		logic [WORKER_W-1:0] worker;
		logic                kind;
		logic [IDX_W-1:0]    idx;
	} reply_t;

	// status table access from the sequencer
	typedef struct packed {
		logic                rd_en;
		logic [ADDR_W-1:0]   raddr;
		logic                wr_en;
		logic [ADDR_W-1:0]   waddr;
		logic [STATUS_W-1:0] wdata;
		logic                clr_map;
		logic                clr_reduce;
	} mem_req_t;

endpackage
`default_nettype wire

FILE: rtl/core/tdt_status_mem.sv
// status table of all map and reduce tasks, with per-entry valid bits
`default_nettype none
module tdt_status_mem (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire tdt_pkg::mem_req_t             req,
	output logic [tdt_pkg::STATUS_W-1:0]       rstatus
);

	logic [tdt_pkg::STATUS_W-1:0] mem [tdt_pkg::DEPTH];
	logic [tdt_pkg::DEPTH-1:0]    valid_q;
	logic [tdt_pkg::STATUS_W-1:0] rdata_q;
	logic                         rvalid_q;

	// storage array, registered read
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.rd_en) begin
			rdata_q <= mem[req.raddr];
		end
	end

	// valid bits: map tasks in the lower half, reduce tasks in the upper half
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (req.clr_map) begin
				valid_q[tdt_pkg::TASKS_MAX-1:0] <= '0;
			end
			if (req.clr_reduce) begin
				valid_q[tdt_pkg::DEPTH-1:tdt_pkg::TASKS_MAX] <= '0;
			end
			if (req.wr_en) begin
				valid_q[req.waddr] <= 1'b1;
			end
			if (req.rd_en) begin
				rvalid_q <= valid_q[req.raddr];
			end
		end
	end

	// an entry never written reads as unassigned
	assign rstatus = rvalid_q ? rdata_q : tdt_pkg::ST_UNASSIGNED;

endmodule
`default_nettype wire

FILE: rtl/core/tdt_seq.sv
// sequencer: phase counts, table scan and completion handling
`default_nettype none
module tdt_seq (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [tdt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tdt_pkg::CNT_W-1:0]     cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire tdt_pkg::item_t                item,
	input  wire logic                          out_free,
	output logic                               res_load,
	output tdt_pkg::reply_t                    res,
	output tdt_pkg::mem_req_t                  mreq,
	input  wire logic [tdt_pkg::STATUS_W-1:0]  rstatus
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_DONE_RD = 3'd1;
	localparam logic [2:0] S_DONE_CK = 3'd2;
	localparam logic [2:0] S_SCAN    = 3'd3;
	localparam logic [2:0] S_OUT     = 3'd4;

	localparam logic [tdt_pkg::CNT_W-1:0] CNT_MAX = tdt_pkg::CNT_W'(tdt_pkg::TASKS_MAX);
	localparam logic [tdt_pkg::CNT_W-1:0] CNT_ONE = tdt_pkg::CNT_W'(1);

	logic [2:0]                   state_q;
	logic [tdt_pkg::CNT_W-1:0]    map_cnt_q, red_cnt_q, map_rem_q, red_rem_q;
	logic [tdt_pkg::CNT_W-1:0]    ptr_q;
	logic [tdt_pkg::IDX_W-1:0]    chk_q;
	logic                         rdv_q;
	logic                         phase_q;
	logic                         kind_q;
	logic [tdt_pkg::IDX_W-1:0]    idx_q;
	tdt_pkg::reply_t              res_q;

	logic                         accept;
	logic [tdt_pkg::CNT_W-1:0]    cfg_clamped;
	logic [tdt_pkg::CNT_W-1:0]    cnt_cur;
	logic [tdt_pkg::CNT_W-1:0]    kind_cnt;
	logic                         in_range;
	logic                         hit, last, empty, issue;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign cfg_clamped = (cfg_wdata > CNT_MAX) ? CNT_MAX : cfg_wdata;

	// scan bookkeeping for the phase being served
	assign cnt_cur  = phase_q ? red_cnt_q : map_cnt_q;
	assign hit      = rdv_q && (rstatus == tdt_pkg::ST_UNASSIGNED);
	assign last     = rdv_q && ((tdt_pkg::CNT_W'(chk_q) + CNT_ONE) == cnt_cur);
	assign empty    = !rdv_q && (ptr_q >= cnt_cur);
	assign issue    = (state_q == S_SCAN) && !hit && (ptr_q < cnt_cur);

	// range check of an incoming completion
	assign kind_cnt = item.kind ? red_cnt_q : map_cnt_q;
	assign in_range = tdt_pkg::CNT_W'(item.idx) < kind_cnt;

	assign res_load = (state_q == S_OUT) && out_free;
	assign res      = res_q;

	// status table requests
	always_comb begin
		mreq            = '0;
		mreq.clr_map    = cfg_we && (cfg_index == tdt_pkg::REG_MAP_COUNT);
		mreq.clr_reduce = cfg_we && (cfg_index == tdt_pkg::REG_REDUCE_COUNT);
		case (state_q)
			S_DONE_RD: begin
				mreq.rd_en = 1'b1;
				mreq.raddr = {kind_q, idx_q};
			end
			S_DONE_CK: begin
				mreq.wr_en = (rstatus != tdt_pkg::ST_COMPLETED);
				mreq.waddr = {kind_q, idx_q};
				mreq.wdata = tdt_pkg::ST_COMPLETED;
			end
			S_SCAN: begin
				mreq.rd_en = issue;
				mreq.raddr = {phase_q, ptr_q[tdt_pkg::IDX_W-1:0]};
				mreq.wr_en = hit;
				mreq.waddr = {phase_q, chk_q};
				mreq.wdata = tdt_pkg::ST_PENDING;
			end
			default: begin
			end
		endcase
	end

	// control sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			map_cnt_q <= '0;
			red_cnt_q <= '0;
			map_rem_q <= '0;
			red_rem_q <= '0;
			ptr_q     <= '0;
			rdv_q     <= 1'b0;
		end else begin
			// configuration write: to be done only while idle, which the block itself does not enforce
			if (cfg_we && (cfg_index == tdt_pkg::REG_MAP_COUNT)) begin
				map_cnt_q <= cfg_clamped;
				map_rem_q <= cfg_clamped;
			end
			if (cfg_we && (cfg_index == tdt_pkg::REG_REDUCE_COUNT)) begin
				red_cnt_q <= cfg_clamped;
				red_rem_q <= cfg_clamped;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						ptr_q <= '0;
						rdv_q <= 1'b0;
						if (item.req_type == tdt_pkg::REQ_DONE) begin
							if (in_range) begin
								state_q <= S_DONE_RD;
							end
						end else if ((map_rem_q != '0) || (red_rem_q != '0)) begin
							state_q <= S_SCAN;
						end
					end
				end
				S_DONE_RD: begin
					state_q <= S_DONE_CK;
				end
				S_DONE_CK: begin
					// repeated completion leaves everything as it is
					if (rstatus != tdt_pkg::ST_COMPLETED) begin
						if (kind_q == tdt_pkg::KIND_MAP) begin
							if (map_rem_q != '0) begin
								map_rem_q <= map_rem_q - CNT_ONE;
							end
						end else if (red_rem_q != '0) begin
							red_rem_q <= red_rem_q - CNT_ONE;
						end
					end
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					rdv_q <= issue;
					if (issue) begin
						ptr_q <= ptr_q + CNT_ONE;
					end
					if (hit || last || empty) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item and reply payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q     <= item.kind;
			idx_q      <= item.idx;
			res_q.worker <= item.worker;
			phase_q    <= (map_rem_q != '0) ? tdt_pkg::KIND_MAP : tdt_pkg::KIND_REDUCE;
		end
		if (issue) begin
			chk_q <= ptr_q[tdt_pkg::IDX_W-1:0];
		end
		if (state_q == S_SCAN) begin
			if (hit) begin
				res_q.code <= tdt_pkg::REPLY_ASSIGNED;
				res_q.kind <= phase_q;
				res_q.idx  <= chk_q;
			end else begin
				res_q.code <= tdt_pkg::REPLY_NONE;
				res_q.kind <= tdt_pkg::KIND_MAP;
				res_q.idx  <= '0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/two_phase_task_dispatcher.sv
// Two-phase task dispatcher. Workers send task requests and completion reports
// on the slave stream; each request is answered on the master stream with the
// lowest unassigned map task while map work is unfinished, then with reduce
// tasks, or with a "no more tasks" reply; once all work is done a request gets
// no reply, and a completion never gets one. One message is handled at a time.
// A completion reads its table entry, then marks it completed (nothing when its
// index is out of range); a request scans up to count entries (count being the task
// count of the phase served, at most 64), or none when all work is done: the single
// read port of the status RAM examines one table entry per cycle. A request whose
// reply finds an earlier reply still waiting for the receiver stays in the block
// until that one leaves. Writing a task count resets that phase's entries at once
// through per-entry valid bits, so no clearing pass is needed after reset.
`default_nettype none
module two_phase_task_dispatcher (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [tdt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tdt_pkg::CNT_W-1:0]      cfg_wdata,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// worker_id [3:0], done_kind [4], done_index [10:5], zero [15:11]
	input  wire logic [tdt_pkg::TDATA_W-1:0]    s_tdata,
	// req_type [0]
	input  wire logic                           s_tuser,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// dest_worker [3:0], task_kind [4], task_index [10:5], zero [15:11]
	output logic [tdt_pkg::TDATA_W-1:0]         m_tdata,
	// reply_code [0]
	output logic                                m_tuser
);

	localparam int PAD_W = tdt_pkg::TDATA_W - tdt_pkg::WORKER_W - 1 - tdt_pkg::IDX_W;

	tdt_pkg::item_t               item;
	tdt_pkg::reply_t              res;
	tdt_pkg::reply_t              m_res_q;
	tdt_pkg::mem_req_t            mreq;
	logic [tdt_pkg::STATUS_W-1:0] rstatus;
	logic                         res_load;
	logic                         out_free;
	logic                         m_valid_q;

	// unpack the incoming message
	assign item.req_type = s_tuser;
	assign item.worker   = s_tdata[tdt_pkg::WORKER_W-1:0];
	assign item.kind     = s_tdata[tdt_pkg::WORKER_W];
	assign item.idx      = s_tdata[tdt_pkg::WORKER_W+tdt_pkg::IDX_W:tdt_pkg::WORKER_W+1];

	tdt_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.item      (item),
		.out_free  (out_free),
		.res_load  (res_load),
		.res       (res),
		.mreq      (mreq),
		.rstatus   (rstatus)
	);

	tdt_status_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mreq),
		.rstatus (rstatus)
	);

	// output register
	assign out_free = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_res_q.code;
	assign m_tdata  = {{PAD_W{1'b0}}, m_res_q.idx, m_res_q.kind, m_res_q.worker};

endmodule
`default_nettype wire

FILE: rtl/core/tdt_checker.sv
// port-level checks of the dispatcher and their binding
`default_nettype none
`include "two_phase_task_dispatcher_assert.svh"
module tdt_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	input  wire logic                           s_tready,
	input  wire logic                           s_tuser,
	input  wire logic                           m_tvalid,
	input  wire logic                           m_tready,
	input  wire logic [tdt_pkg::TDATA_W-1:0]    m_tdata,
	input  wire logic                           m_tuser
);

	// a stalled reply stays offered
	`TDT_ASSERT_NEXT(a_reply_held, clk, arst_n, m_tvalid && !m_tready, m_tvalid)

	// a no-more-tasks reply carries no task
	`TDT_ASSERT_SAME(a_none_empty, clk, arst_n, m_tvalid && (m_tuser == tdt_pkg::REPLY_NONE), m_tdata[tdt_pkg::TDATA_W-1:tdt_pkg::WORKER_W] == '0)

	// a completion transfer never produces a reply right after it
	`TDT_ASSERT_NEXT(a_done_silent, clk, arst_n, s_tvalid && s_tready && (s_tuser == tdt_pkg::REQ_DONE) && !m_tvalid, !m_tvalid)

endmodule

bind two_phase_task_dispatcher tdt_checker u_tdt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire
